// ===== rtl/core/lattice_gas_collide_stream_unit_macros.svh =====
// Assertion helpers shared by the core files.
`ifndef LATTICE_GAS_COLLIDE_STREAM_UNIT_MACROS_SVH
`define LATTICE_GAS_COLLIDE_STREAM_UNIT_MACROS_SVH

`ifndef SYNTH
`define LGCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define LGCS_ASSERT(lbl, prop, msg)
`define LGCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lgcs_pkg.sv =====
package lgcs_pkg;

   localparam int MAX_SIDE  = 16;
   localparam int NUM_CHAN  = 343;
   localparam int NUM_WORDS = 6;
   localparam int WORD_W    = 64;
   localparam int VEL_SPAN  = 7;
   localparam int PLANE     = VEL_SPAN * VEL_SPAN;
   localparam int DEPTH     = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int COORD_W   = $clog2(MAX_SIDE);
   localparam int SIDE_W    = 5;
   localparam int SQ_W      = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int CHAN_W    = 9;
   localparam int WSEL_W    = 3;
   localparam int TAIL_BITS = NUM_CHAN - (NUM_WORDS - 1) * WORD_W;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_BAD       = 2'd1;
   localparam logic [1:0] STS_EXHAUSTED = 2'd2;

   localparam logic [2:0] DIG_MAX = 3'(VEL_SPAN - 1);

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] row_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DONE, ST_CREAD, ST_CSTART, ST_CWAIT,
      ST_SPULL, ST_SDRAIN, ST_COPY, ST_CDRAIN
   } state_type;

   typedef enum logic [1:0] {PS_IDLE, PS_SCAN, PS_KEY, PS_SEARCH} pair_state_type;

   typedef struct packed {
      logic              change;
      logic [CHAN_W-1:0] lo;
      logic [CHAN_W-1:0] hi;
   } pair_res_type;

   typedef struct packed {
      logic [2:0] x;
      logic [2:0] y;
      logic [2:0] z;
   } digits_type;

   // channel -> per-axis digit (velocity + 3)
   function automatic digits_type chan_digits(input logic [CHAN_W-1:0] c);
      digits_type        d;
      logic [CHAN_W-1:0] r;
      d = '0;
      for (int k = 1; k < VEL_SPAN; k++)
         if (c >= CHAN_W'(PLANE * k)) d.x = 3'(k);
      r = c - CHAN_W'(d.x) * CHAN_W'(PLANE);
      for (int k = 1; k < VEL_SPAN; k++)
         if (r >= CHAN_W'(VEL_SPAN * k)) d.y = 3'(k);
      r = r - CHAN_W'(d.y) * CHAN_W'(VEL_SPAN);
      d.z = r[2:0];
      return d;
   endfunction

   function automatic logic [3:0] sq3(input logic [2:0] d);
      int v;
      v = int'(d) - 3;
      return 4'(v * v);
   endfunction

   function automatic logic [5:0] lsb64(input logic [WORD_W-1:0] w);
      logic [5:0] idx;
      idx = '0;
      for (int k = WORD_W - 1; k >= 0; k--)
         if (w[k]) idx = 6'(k);
      return idx;
   endfunction

   // true when a channel digit hops by the step opposite to source offset o
   function automatic logic hop_match(input int d, input logic [1:0] phase,
                                      input logic [1:0] o);
      int v;
      int mag;
      int h;
      v   = d - 3;
      mag = (v < 0) ? -v : v;
      h   = (v != 0 && mag >= int'(phase)) ? ((v > 0) ? 1 : -1) : 0;
      return h == (1 - int'(o));
   endfunction

   // channels that arrive from the neighbor at offset (ox,oy,oz) - 1
   function automatic row_type stream_mask(input logic [1:0] phase, input logic [1:0] ox,
                                           input logic [1:0] oy, input logic [1:0] oz);
      row_type m;
      int      c;
      m = '0;
      for (int dx = 0; dx < VEL_SPAN; dx++)
         for (int dy = 0; dy < VEL_SPAN; dy++)
            for (int dz = 0; dz < VEL_SPAN; dz++) begin
               c = PLANE * dx + VEL_SPAN * dy + dz;
               if (hop_match(dx, phase, ox) && hop_match(dy, phase, oy) &&
                   hop_match(dz, phase, oz))
                  m[c / WORD_W][c % WORD_W] = 1'b1;
            end
      return m;
   endfunction

endpackage

// ===== rtl/core/lgcs_site_ram.sv =====
module lgcs_site_ram import lgcs_pkg::*; (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output row_type              rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [NUM_WORDS-1:0] wr_mask,
   input  row_type              wr_data
);

   row_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int w = 0; w < NUM_WORDS; w++)
            if (wr_mask[w]) mem[wr_addr][w] <= wr_data[w];
      end
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/lgcs_pair_unit.sv =====
`include "lattice_gas_collide_stream_unit_macros.svh"
module lgcs_pair_unit import lgcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  row_type      row,
   output logic         done,
   output pair_res_type res
);

   pair_state_type    state_ff, state_in;
   row_type           row_ff, row_in;
   logic [WSEL_W-1:0] word_ff, word_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [CHAN_W-1:0] first_ff, first_in, second_ff, second_in;
   logic [3:0]        sdx_ff, sdx_in, sdy_ff, sdy_in, sdz_ff, sdz_in;
   logic [5:0]        e_ff, e_in;
   logic [CHAN_W-1:0] cand_ff, cand_in;
   digits_type        cd_ff, cd_in;
   logic              done_ff, done_in;
   pair_res_type      res_ff, res_in;

   logic [WORD_W-1:0] cur, w2, w3;
   logic [1:0]        wc;
   logic [2:0]        cnt_sum;
   digits_type        da, db, dn;
   logic [4:0]        bdx, bdy, bdz;
   logic              b_ok, hit;
   logic [CHAN_W-1:0] bch;
   logic [5:0]        ec;

   always_comb begin
      cur     = row_ff[word_ff];
      w2      = cur & (cur - WORD_W'(1));
      w3      = w2 & (w2 - WORD_W'(1));
      wc      = 2'(cur != '0) + 2'(w2 != '0) + 2'(w3 != '0);
      cnt_sum = 3'(cnt_ff) + 3'(wc);

      da = chan_digits(first_ff);
      db = chan_digits(second_ff);
      dn = chan_digits(first_ff + CHAN_W'(1));

      // partner implied by momentum: b = sum - a on each axis
      bdx  = {1'b0, sdx_ff} - {2'b0, cd_ff.x};
      bdy  = {1'b0, sdy_ff} - {2'b0, cd_ff.y};
      bdz  = {1'b0, sdz_ff} - {2'b0, cd_ff.z};
      b_ok = !bdx[4] && bdx[3:0] <= 4'(DIG_MAX) && !bdy[4] && bdy[3:0] <= 4'(DIG_MAX) &&
             !bdz[4] && bdz[3:0] <= 4'(DIG_MAX);
      bch  = CHAN_W'(bdx[2:0]) * CHAN_W'(PLANE) + CHAN_W'(bdy[2:0]) * CHAN_W'(VEL_SPAN) +
             CHAN_W'(bdz[2:0]);
      ec   = 6'(sq3(cd_ff.x)) + 6'(sq3(cd_ff.y)) + 6'(sq3(cd_ff.z)) +
             6'(sq3(bdx[2:0])) + 6'(sq3(bdy[2:0])) + 6'(sq3(bdz[2:0]));
      hit  = b_ok && bch > cand_ff && ec == e_ff;
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      second_in = second_ff;
      sdx_in    = sdx_ff;
      sdy_in    = sdy_ff;
      sdz_in    = sdz_ff;
      e_in      = e_ff;
      cand_in   = cand_ff;
      cd_in     = cd_ff;
      done_in   = 1'b0;
      res_in    = res_ff;
      case (state_ff)
         PS_IDLE: begin
            if (start) begin
               row_in   = row;
               word_in  = '0;
               cnt_in   = '0;
               state_in = PS_SCAN;
            end
         end
         PS_SCAN: begin
            if (cur != '0) begin
               if (cnt_ff == 2'd0) begin
                  first_in  = {word_ff, lsb64(cur)};
                  second_in = {word_ff, lsb64(w2)};
               end else if (cnt_ff == 2'd1) begin
                  second_in = {word_ff, lsb64(cur)};
               end
            end
            cnt_in  = (cnt_sum > 3'd3) ? 2'd3 : cnt_sum[1:0];
            word_in = word_ff + WSEL_W'(1);
            if (word_ff == WSEL_W'(NUM_WORDS - 1)) begin
               if (cnt_in == 2'd2) begin
                  state_in = PS_KEY;
               end else begin
                  done_in       = 1'b1;
                  res_in.change = 1'b0;
                  state_in      = PS_IDLE;
               end
            end
         end
         PS_KEY: begin
            sdx_in   = 4'(da.x) + 4'(db.x);
            sdy_in   = 4'(da.y) + 4'(db.y);
            sdz_in   = 4'(da.z) + 4'(db.z);
            e_in     = 6'(sq3(da.x)) + 6'(sq3(da.y)) + 6'(sq3(da.z)) +
                       6'(sq3(db.x)) + 6'(sq3(db.y)) + 6'(sq3(db.z));
            cand_in  = first_ff + CHAN_W'(1);
            cd_in    = dn;
            state_in = PS_SEARCH;
         end
         PS_SEARCH: begin
            if (hit) begin
               done_in       = 1'b1;
               res_in.change = 1'b1;
               res_in.lo     = cand_ff;
               res_in.hi     = bch;
               state_in      = PS_IDLE;
            end else if (cand_ff == CHAN_W'(NUM_CHAN - 1)) begin
               cand_in = '0;
               cd_in   = '0;
            end else begin
               cand_in = cand_ff + CHAN_W'(1);
               if (cd_ff.z == DIG_MAX) begin
                  cd_in.z = '0;
                  if (cd_ff.y == DIG_MAX) begin
                     cd_in.y = '0;
                     cd_in.x = cd_ff.x + 3'd1;
                  end else begin
                     cd_in.y = cd_ff.y + 3'd1;
                  end
               end else begin
                  cd_in.z = cd_ff.z + 3'd1;
               end
            end
         end
         default: state_in = PS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      row_ff    <= row_in;
      word_ff   <= word_in;
      cnt_ff    <= cnt_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      sdx_ff    <= sdx_in;
      sdy_ff    <= sdy_in;
      sdz_ff    <= sdz_in;
      e_ff      <= e_in;
      cand_ff   <= cand_in;
      cd_ff     <= cd_in;
      res_ff    <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

   `LGCS_ASSERT(a_start_idle, start |-> state_ff == PS_IDLE, "pair start while busy")
   `LGCS_ASSERT(a_pair_order, done_ff && res_ff.change |-> res_ff.lo < res_ff.hi, "pair order")
   `LGCS_ASSERT_NEXT(a_done_idle, done_in, state_ff == PS_IDLE, "done without idle")

endmodule

// ===== rtl/core/lattice_gas_collide_stream_unit.sv =====
// channel | ports                                       | accepted when
// req     | req_valid/req_ready, action site word data  | req_valid & req_ready
// rsp     | rsp_valid/rsp_ready, read_data status phase | rsp_valid & rsp_ready
// csr     | csr_write_enable, csr_write_data (side L)   | csr_write_enable
// Word write goes from IDLE straight to DONE; word read passes ST_READ (one memory read).
// Collision tick: per site a row read, a pair-unit start and a wait; the wait is longer when the site
//   holds a pair (successor search walks one candidate channel per cycle in the pair unit).
// Streaming tick: per site 27 neighbor reads of the site memory and a scratch write, then
//   a pass copying the scratch memory back.
// After reset the site memory is cleared, all 4096 sites; req_ready stays low meanwhile.
// A waiting result does not stall a new item; it stalls only the next completion.
`include "lattice_gas_collide_stream_unit_macros.svh"
module lattice_gas_collide_stream_unit import lgcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [11:0]         req_site,
   input  logic [2:0]          req_word_index,
   input  logic [63:0]         req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [63:0]         rsp_read_data,
   output logic [1:0]          rsp_status,
   output logic [1:0]          rsp_phase_now,
   input  logic                csr_write_enable,
   input  logic [SIDE_W-1:0]   csr_write_data
);

   state_type          state_ff, state_in;
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [63:0]        tick_ff, tick_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]         ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [1:0]         plx_ff, plx_in, ply_ff, ply_in, plz_ff, plz_in;
   logic               pl_vld_ff, pl_vld_in, cp_vld_ff, cp_vld_in;
   logic [ADDR_W-1:0]  cp_addr_ff, cp_addr_in;
   row_type            acc_ff, acc_in;
   logic [WSEL_W-1:0]  word_ff, word_in;
   logic [63:0]        res_data_ff, res_data_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [1:0]         rsp_phase_ff, rsp_phase_in;

   logic                 site_re, site_we, nxt_re, nxt_we;
   logic [ADDR_W-1:0]    site_raddr, site_waddr;
   logic [NUM_WORDS-1:0] site_wmask;
   row_type              site_rdata, site_wdata, nxt_rdata, acc_gather, pair_row;
   logic                 pair_start, pair_done, tick_step;
   pair_res_type         pair_res;

   logic [SIDE_W-1:0]  sat;
   logic [9:0]         sq_full;
   logic               last_site, bad_addr, tail_bad, x_end, y_end;
   logic [COORD_W-1:0] sx, sy, sz, side_top;
   logic [CNT_W-1:0]   src_full;

   // configuration
   always_comb begin
      sat = csr_write_data;
      if (csr_write_data < SIDE_W'(3)) sat = SIDE_W'(3);
      if (csr_write_data > SIDE_W'(MAX_SIDE)) sat = SIDE_W'(MAX_SIDE);
      sq_full = 10'(sat) * 10'(sat);
      side_in = csr_write_enable ? sat : side_ff;
      sq_in   = csr_write_enable ? sq_full[SQ_W-1:0] : sq_ff;
      n_in    = csr_write_enable ? CNT_W'(sq_full[SQ_W-1:0]) * CNT_W'(sat) : n_ff;
   end

   // neighbor address for a pull in the streaming pass
   always_comb begin
      side_top = COORD_W'(side_ff - SIDE_W'(1));
      x_end    = x_ff == side_top;
      y_end    = y_ff == side_top;
      case (ox_ff)
         2'd0:    sx = (x_ff == '0) ? side_top : x_ff - COORD_W'(1);
         2'd2:    sx = x_end ? '0 : x_ff + COORD_W'(1);
         default: sx = x_ff;
      endcase
      case (oy_ff)
         2'd0:    sy = (y_ff == '0) ? side_top : y_ff - COORD_W'(1);
         2'd2:    sy = y_end ? '0 : y_ff + COORD_W'(1);
         default: sy = y_ff;
      endcase
      case (oz_ff)
         2'd0:    sz = (z_ff == '0) ? side_top : z_ff - COORD_W'(1);
         2'd2:    sz = (z_ff == side_top) ? '0 : z_ff + COORD_W'(1);
         default: sz = z_ff;
      endcase
      src_full = CNT_W'(sx) + CNT_W'(side_ff) * CNT_W'(sy) + CNT_W'(sq_ff) * CNT_W'(sz);
   end

   always_comb begin
      acc_gather = pl_vld_ff ?
                   (acc_ff | (site_rdata & stream_mask(tick_ff[1:0], plx_ff, ply_ff, plz_ff))) :
                   acc_ff;
      pair_row = '0;
      pair_row[pair_res.lo[8:6]][pair_res.lo[5:0]] = 1'b1;
      pair_row[pair_res.hi[8:6]][pair_res.hi[5:0]] = 1'b1;
      last_site = {1'b0, idx_ff} == n_ff - CNT_W'(1);
      bad_addr  = {1'b0, req_site} >= n_ff || req_word_index > WSEL_W'(NUM_WORDS - 1);
      tail_bad  = req_word_index == WSEL_W'(NUM_WORDS - 1) &&
                  req_write_data[63:TAIL_BITS] != '0;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      oz_in         = oz_ff;
      plx_in        = ox_ff;
      ply_in        = oy_ff;
      plz_in        = oz_ff;
      pl_vld_in     = 1'b0;
      cp_vld_in     = 1'b0;
      cp_addr_in    = idx_ff;
      acc_in        = acc_ff;
      word_in       = word_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_phase_in  = rsp_phase_ff;
      site_re       = 1'b0;
      site_raddr    = idx_ff;
      site_we       = 1'b0;
      site_waddr    = idx_ff;
      site_wmask    = '1;
      site_wdata    = '0;
      nxt_re        = 1'b0;
      nxt_we        = 1'b0;
      pair_start    = 1'b0;
      tick_step     = 1'b0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            site_we = 1'b1;
            idx_in  = idx_ff + ADDR_W'(1);
            if (idx_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_data_in   = '0;
               res_status_in = STS_OK;
               word_in       = req_word_index;
               state_in      = ST_DONE;
               case (req_action)
                  ACT_WRITE: begin
                     if (bad_addr || tail_bad) begin
                        res_status_in = STS_BAD;
                     end else begin
                        site_we    = 1'b1;
                        site_waddr = req_site;
                        site_wmask = NUM_WORDS'(1) << req_word_index;
                        site_wdata = {NUM_WORDS{req_write_data}};
                     end
                  end
                  ACT_READ: begin
                     if (bad_addr) begin
                        res_status_in = STS_BAD;
                     end else begin
                        site_re    = 1'b1;
                        site_raddr = req_site;
                        state_in   = ST_READ;
                     end
                  end
                  ACT_TICK: begin
                     if (&tick_ff) begin
                        res_status_in = STS_EXHAUSTED;
                     end else begin
                        idx_in   = '0;
                        x_in     = '0;
                        y_in     = '0;
                        z_in     = '0;
                        ox_in    = '0;
                        oy_in    = '0;
                        oz_in    = '0;
                        acc_in   = '0;
                        state_in = (tick_ff[1:0] == 2'd0) ? ST_CREAD : ST_SPULL;
                     end
                  end
                  default: res_status_in = STS_BAD;
               endcase
            end
         end
         ST_READ: begin
            res_data_in = site_rdata[word_ff];
            state_in    = ST_DONE;
         end
         ST_CREAD: begin
            site_re  = 1'b1;
            state_in = ST_CSTART;
         end
         ST_CSTART: begin
            pair_start = 1'b1;
            state_in   = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (pair_done) begin
               if (pair_res.change) begin
                  site_we    = 1'b1;
                  site_wdata = pair_row;
               end
               if (last_site) begin
                  tick_step = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_CREAD;
               end
            end
         end
         ST_SPULL: begin
            site_re    = 1'b1;
            site_raddr = src_full[ADDR_W-1:0];
            pl_vld_in  = 1'b1;
            acc_in     = acc_gather;
            if (oz_ff == 2'd2) begin
               oz_in = '0;
               if (oy_ff == 2'd2) begin
                  oy_in = '0;
                  if (ox_ff == 2'd2) begin
                     ox_in    = '0;
                     state_in = ST_SDRAIN;
                  end else begin
                     ox_in = ox_ff + 2'd1;
                  end
               end else begin
                  oy_in = oy_ff + 2'd1;
               end
            end else begin
               oz_in = oz_ff + 2'd1;
            end
         end
         ST_SDRAIN: begin
            nxt_we = 1'b1;
            acc_in = '0;
            if (last_site) begin
               idx_in   = '0;
               state_in = ST_COPY;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_SPULL;
               if (x_end) begin
                  x_in = '0;
                  if (y_end) begin
                     y_in = '0;
                     z_in = z_ff + COORD_W'(1);
                  end else begin
                     y_in = y_ff + COORD_W'(1);
                  end
               end else begin
                  x_in = x_ff + COORD_W'(1);
               end
            end
         end
         ST_COPY: begin
            nxt_re    = 1'b1;
            cp_vld_in = 1'b1;
            if (cp_vld_ff) begin
               site_we    = 1'b1;
               site_waddr = cp_addr_ff;
               site_wdata = nxt_rdata;
            end
            if (last_site) state_in = ST_CDRAIN;
            else idx_in = idx_ff + ADDR_W'(1);
         end
         ST_CDRAIN: begin
            site_we    = 1'b1;
            site_waddr = cp_addr_ff;
            site_wdata = nxt_rdata;
            tick_step  = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_phase_in  = tick_ff[1:0];
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      tick_in = tick_step ? tick_ff + 64'd1 : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         side_ff      <= SIDE_W'(MAX_SIDE);
         sq_ff        <= SQ_W'(MAX_SIDE * MAX_SIDE);
         n_ff         <= CNT_W'(DEPTH);
         tick_ff      <= '0;
         pl_vld_ff    <= 1'b0;
         cp_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         side_ff      <= side_in;
         sq_ff        <= sq_in;
         n_ff         <= n_in;
         tick_ff      <= tick_in;
         pl_vld_ff    <= pl_vld_in;
         cp_vld_ff    <= cp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      oz_ff         <= oz_in;
      plx_ff        <= plx_in;
      ply_ff        <= ply_in;
      plz_ff        <= plz_in;
      cp_addr_ff    <= cp_addr_in;
      acc_ff        <= acc_in;
      word_ff       <= word_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phase_ff  <= rsp_phase_in;
   end

   lgcs_site_ram u_site_store (
      .clock   (clock),
      .rd_en   (site_re),
      .rd_addr (site_raddr),
      .rd_data (site_rdata),
      .wr_en   (site_we),
      .wr_addr (site_waddr),
      .wr_mask (site_wmask),
      .wr_data (site_wdata)
   );

   lgcs_site_ram u_next_store (
      .clock   (clock),
      .rd_en   (nxt_re),
      .rd_addr (idx_ff),
      .rd_data (nxt_rdata),
      .wr_en   (nxt_we),
      .wr_addr (idx_ff),
      .wr_mask ('1),
      .wr_data (acc_gather)
   );

   lgcs_pair_unit u_pair (
      .clock (clock),
      .reset (reset),
      .start (pair_start),
      .row   (site_rdata),
      .done  (pair_done),
      .res   (pair_res)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_phase_now = rsp_phase_ff;

   `LGCS_ASSERT(a_tick_step, !$stable(tick_ff) |-> $past(tick_step), "tick moved off step")
   `LGCS_ASSERT(a_next_range, nxt_we |-> ({1'b0, idx_ff} < n_ff), "scratch write past lattice")
   `LGCS_ASSERT_NEXT(a_pull_drain, state_ff == ST_SPULL && state_in == ST_SDRAIN, pl_vld_ff, "drain lost last pull")

endmodule
